// File: src/fwm_pkg.sv
// Shared types, character codes and byte folding for the wildcard matcher.
package fwm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic append;
    logic step;
    logic restart;
  } cell_ctrl_t;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_PIPE     = 8'h7C;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end else begin
      case (c)
        CH_LBRACKET: r = CH_LBRACE;
        CH_RBRACKET: r = CH_RBRACE;
        CH_BSLASH:   r = CH_PIPE;
        CH_TILDE:    r = CH_CARET;
        default:     r = c;
      endcase
    end
    return r;
  endfunction

endpackage

// File: src/folded_wildcard_matcher_unit.sv
// Folded glob matcher: a row of position cells with a star-closure adder.
// An end-of-text request gives its registered result in the cycle after acceptance.
// Throughput: one request per cycle; each text byte updates every position at once.
// A held result stalls further requests until it is taken.
// Reset (synchronous): empty pattern, no overflow, only position zero active.
module folded_wildcard_matcher_unit #(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] byte_value,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       matched,
  output logic       pattern_overflow
);
  import fwm_pkg::*;

  localparam int N     = MAX_PATTERN;
  localparam int LEN_W = $clog2(N + 1);
  localparam logic [LEN_W-1:0] N_L = LEN_W'(N);

  logic             accept;
  logic [7:0]       folded;
  cmd_t             op;
  cell_ctrl_t       ctrl;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] lead;
  logic [LEN_W-1:0] lead_next;
  logic             ovf;
  logic             ovf_next;
  logic             active_last;
  logic [N:0]       active_vec;
  logic [N:0]       raw_vec;
  logic [N:0]       prop_vec;
  logic [N:0]       closed_vec;
  logic [N:0]       adv;

  assign cmd_ready = !result_valid || result_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign folded    = fold_byte(byte_value);
  assign op        = cmd_t'(cmd);

  assign ctrl.append  = accept && op == CMD_APPEND;
  assign ctrl.step    = accept && op == CMD_TEXT;
  assign ctrl.restart = accept && op != CMD_TEXT;

  always_comb begin
    len_next  = len;
    lead_next = lead;
    ovf_next  = ovf;
    if (accept) begin
      case (op)
        CMD_CLEAR: begin
          len_next  = '0;
          lead_next = '0;
          ovf_next  = 1'b0;
        end
        CMD_APPEND: begin
          if (len < N_L) begin
            len_next = len + 1'b1;
            if (lead == len && folded == CH_STAR) begin
              lead_next = lead + 1'b1;
            end
          end else begin
            ovf_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      lead <= '0;
      ovf  <= 1'b0;
    end else begin
      len  <= len_next;
      lead <= lead_next;
      ovf  <= ovf_next;
    end
  end

  assign adv[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fwm_cell #(
      .LEN_W (LEN_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .byte_value (folded),
      .len        (len),
      .lead_next  (lead_next),
      .adv_in     (adv[i]),
      .closed_in  (closed_vec[i]),
      .active     (active_vec[i]),
      .star       (prop_vec[i]),
      .raw        (raw_vec[i]),
      .adv_out    (adv[i+1])
    );
  end

  assign prop_vec[N]   = 1'b0;
  assign raw_vec[N]    = adv[N];
  assign active_vec[N] = active_last;

  fwm_star_close #(
    .W (N + 1)
  ) u_close (
    .raw    (raw_vec),
    .prop   (prop_vec),
    .closed (closed_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_last <= 1'b0;
    end else if (ctrl.restart) begin
      active_last <= (N_L <= lead_next);
    end else if (ctrl.step) begin
      active_last <= closed_vec[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && op == CMD_END) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == CMD_END) begin
      matched          <= active_vec[len] && !ovf;
      pattern_overflow <= ovf;
    end
  end

endmodule

// File: src/fwm_cell.sv
// One pattern position: stored byte, active bit and advance to the next position.
module fwm_cell #(
  parameter int LEN_W = 7,
  parameter int IDX   = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fwm_pkg::cell_ctrl_t    ctrl,
  input  logic [7:0]             byte_value,
  input  logic [LEN_W-1:0]       len,
  input  logic [LEN_W-1:0]       lead_next,
  input  logic                   adv_in,
  input  logic                   closed_in,
  output logic                   active,
  output logic                   star,
  output logic                   raw,
  output logic                   adv_out
);
  import fwm_pkg::*;

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

  logic [7:0] pchar;
  logic       used;

  always_ff @(posedge clk) begin
    if (ctrl.append && len == IDX_L) begin
      pchar <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (IDX_L == '0);
    end else if (ctrl.restart) begin
      active <= (IDX_L <= lead_next);
    end else if (ctrl.step) begin
      active <= closed_in;
    end
  end

  assign used    = IDX_L < len;
  assign star    = used && pchar == CH_STAR;
  assign raw     = (active && star) || adv_in;
  assign adv_out = active && used && !star &&
                   (pchar == CH_QUESTION || pchar == byte_value);

endmodule

// File: src/fwm_star_close.sv
// Star closure: carries active positions through runs of '*' with one add.
module fwm_star_close #(
  parameter int W = 65
) (
  input  logic [W-1:0] raw,
  input  logic [W-1:0] prop,
  output logic [W-1:0] closed
);
  logic [W-1:0] gen;
  logic [W-1:0] sum;
  logic [W-1:0] carry;

  assign gen    = raw & prop;
  assign sum    = prop + gen;
  assign carry  = sum ^ prop ^ gen;
  assign closed = raw | carry;

endmodule
